// ----- design/sbmq_pkg.sv -----
// Shared types and codes for the shared-buffer multi-queue block.
package sbmq_pkg;

	// Operation carried by an input item
	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} opcode_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EXEC
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;  // latch item, read queue head and tail
		logic read;    // read link and data, write new slot for a push
		logic exec;    // update pointers and load the result register
	} sbmq_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_stall;  // result register is full and not being taken
	} sbmq_sts_t;

endpackage

// ----- design/sbmq_req_if.sv -----
// Request channel: one push or pop item.
interface sbmq_req_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic [1:0]         queue_id;
	logic signed [31:0] value;

	modport source (output valid, output opcode, output queue_id, output value, input ready);
	modport sink   (input valid, input opcode, input queue_id, input value, output ready);
endinterface

// ----- design/sbmq_rsp_if.sv -----
// Response channel: status and popped word of one item.
interface sbmq_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] popped_value;

	modport source (output valid, output status, output popped_value, input ready);
	modport sink   (input valid, input status, input popped_value, output ready);
endinterface

// ----- design/sbmq_ctrl.sv -----
// Sequencing state machine for the shared-buffer multi-queue.
module sbmq_ctrl
	import sbmq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  sbmq_sts_t sts,
	output sbmq_cmd_t cmd
);

	state_t state_q;
	state_t state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_next = S_READ;
			end
			S_READ: begin
				state_next = S_EXEC;
			end
			S_EXEC: begin
				if (!sts.out_stall) state_next = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		req_ready  = 1'b0;
		cmd.accept = 1'b0;
		cmd.read   = 1'b0;
		cmd.exec   = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			S_READ: begin
				cmd.read = 1'b1;
			end
			S_EXEC: begin
				cmd.exec = !sts.out_stall;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- design/sbmq_dp.sv -----
// Datapath: pointer registers, queue and slot memories, result register.
module sbmq_dp
	import sbmq_pkg::*;
#(
	parameter int SLOTS     = 64,
	parameter int QUEUES    = 4,
	parameter int DATA_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               opcode,
	input  logic [1:0]         queue_id,
	input  logic signed [31:0] value,
	input  sbmq_cmd_t          cmd,
	output sbmq_sts_t          sts,
	input  logic               rsp_ready,
	output logic               rsp_valid,
	output logic [1:0]         rsp_status,
	output logic signed [31:0] rsp_popped_value
);

	localparam int AW = $clog2(SLOTS);
	localparam int PW = $clog2(SLOTS + 1);
	localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam logic [PW-1:0] NIL = PW'(SLOTS);

	// Memories
	logic [PW-1:0]        head_mem [QUEUES];
	logic [PW-1:0]        tail_mem [QUEUES];
	logic [PW-1:0]        link_mem [SLOTS];
	logic [DATA_BITS-1:0] data_mem [SLOTS];

	// Item registers
	opcode_t              op_q;
	logic [QW-1:0]        qidx_q;
	logic                 qok_q;
	logic [DATA_BITS-1:0] value_q;

	// Pointer state
	logic [PW-1:0]     free_head_q;
	logic [PW-1:0]     fill_q;
	logic [QUEUES-1:0] head_valid_q;

	// Memory read data and decisions taken in the read step
	logic [PW-1:0]        head_rd_q;
	logic [PW-1:0]        tail_rd_q;
	logic [PW-1:0]        link_rd_q;
	logic [DATA_BITS-1:0] data_rd_q;
	logic [PW-1:0]        head_eff_q;
	logic [PW-1:0]        link_addr_q;
	logic                 link_fresh_q;
	logic                 push_ok_q;
	logic                 pop_ok_q;

	// Result register
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [DATA_BITS-1:0] out_data_q;

	logic [QW-1:0]  qidx_in;
	logic [PW-1:0]  head_eff;
	logic [PW-1:0]  link_addr;
	logic           push_ok;
	logic           pop_ok;
	logic [PW-1:0]  link_eff;

	logic           link_we;
	logic [AW-1:0]  link_wa;
	logic [PW-1:0]  link_wd;
	logic           head_we;
	logic [PW-1:0]  head_wd;

	assign qidx_in = QW'(queue_id);
	assign sts.out_stall = out_valid_q && !rsp_ready;

	// Read step decisions
	assign head_eff  = head_valid_q[qidx_q] ? head_rd_q : NIL;
	assign push_ok   = (op_q == OP_PUSH) && qok_q && (free_head_q < NIL);
	assign pop_ok    = (op_q == OP_POP) && qok_q && (head_eff < NIL);
	assign link_addr = (op_q == OP_POP) ? head_eff : free_head_q;

	// Slots at or above the fill mark were never written and still link to the next slot
	assign link_eff = link_fresh_q ? (link_addr_q + PW'(1)) : link_rd_q;

	// Link memory write port
	always_comb begin
		link_we = 1'b0;
		link_wa = AW'(free_head_q);
		link_wd = NIL;
		if (cmd.read && push_ok) begin
			link_we = 1'b1;
			link_wa = AW'(free_head_q);
			link_wd = NIL;
		end else if (cmd.exec && push_ok_q && (head_eff_q < NIL)) begin
			link_we = 1'b1;
			link_wa = AW'(tail_rd_q);
			link_wd = free_head_q;
		end else if (cmd.exec && pop_ok_q) begin
			link_we = 1'b1;
			link_wa = AW'(head_eff_q);
			link_wd = free_head_q;
		end
	end

	// Queue head memory write port
	always_comb begin
		head_we = 1'b0;
		head_wd = free_head_q;
		if (cmd.exec && push_ok_q && !(head_eff_q < NIL)) begin
			head_we = 1'b1;
			head_wd = free_head_q;
		end else if (cmd.exec && pop_ok_q) begin
			head_we = 1'b1;
			head_wd = link_eff;
		end
	end

	// Queue head and tail memories
	always_ff @(posedge clk) begin
		if (head_we) head_mem[qidx_q] <= head_wd;
		if (cmd.exec && push_ok_q) tail_mem[qidx_q] <= free_head_q;
		if (cmd.accept) begin
			head_rd_q <= head_mem[qidx_in];
			tail_rd_q <= tail_mem[qidx_in];
		end
	end

	// Link and data memories
	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_wa] <= link_wd;
		if (cmd.read && push_ok) data_mem[AW'(free_head_q)] <= value_q;
		if (cmd.read) begin
			link_rd_q <= link_mem[AW'(link_addr)];
			data_rd_q <= data_mem[AW'(head_eff)];
		end
	end

	// Item and read-step payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= opcode_t'(opcode);
			qidx_q  <= qidx_in;
			qok_q   <= int'(queue_id) < QUEUES;
			value_q <= DATA_BITS'($unsigned(value));
		end
		if (cmd.read) begin
			head_eff_q   <= head_eff;
			link_addr_q  <= link_addr;
			link_fresh_q <= link_addr >= fill_q;
			push_ok_q    <= push_ok;
			pop_ok_q     <= pop_ok;
		end
	end

	// Free list, fill mark and queue valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q  <= '0;
			fill_q       <= '0;
			head_valid_q <= '0;
		end else if (cmd.exec) begin
			if (push_ok_q) begin
				free_head_q <= link_eff;
				if (link_fresh_q) fill_q <= fill_q + PW'(1);
				if (!(head_eff_q < NIL)) head_valid_q[qidx_q] <= 1'b1;
			end else if (pop_ok_q) begin
				free_head_q <= head_eff_q;
			end
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (op_q == OP_PUSH) begin
				out_status_q <= push_ok_q ? ST_OK : ST_FULL;
				out_data_q   <= '0;
			end else begin
				out_status_q <= pop_ok_q ? ST_OK : ST_EMPTY;
				out_data_q   <= pop_ok_q ? data_rd_q : '0;
			end
		end
	end

	assign rsp_valid        = out_valid_q;
	assign rsp_status       = out_status_q;
	assign rsp_popped_value = $signed(32'(out_data_q));

endmodule

// ----- design/shared_buffer_multi_queue.sv -----
// Top level of the shared-buffer multi-queue: several FIFO queues in one linked store.
//
//  channel  dir  fields                         handshake
//  req      in   opcode, queue_id, value        valid/ready
//  rsp      out  status, popped_value           valid/ready
//
// Each item passes three steps: accept (queue head/tail read), link and data read,
// then pointer update and result load; the chain is set by the dependent reads of
// the queue head memory and then the link memory, each with a registered read port.
// A new item is accepted while the previous result still waits in the output register;
// the update step holds while that register is full and not being taken.
// Reset clears the free-list head, the fill mark and the per-queue valid bits at once;
// no clearing pass is needed, as slots at or above the fill mark read as linking to the next.
module shared_buffer_multi_queue
	import sbmq_pkg::*;
#(
	parameter int SLOTS     = 64,
	parameter int QUEUES    = 4,
	parameter int DATA_BITS = 32
) (
	input logic          clk,
	input logic          arst_n,
	sbmq_req_if.sink     req,
	sbmq_rsp_if.source   rsp
);

	sbmq_cmd_t cmd;
	sbmq_sts_t sts;

	// Controller
	sbmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath
	sbmq_dp #(
		.SLOTS     (SLOTS),
		.QUEUES    (QUEUES),
		.DATA_BITS (DATA_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.opcode           (req.opcode),
		.queue_id         (req.queue_id),
		.value            (req.value),
		.cmd              (cmd),
		.sts              (sts),
		.rsp_ready        (rsp.ready),
		.rsp_valid        (rsp.valid),
		.rsp_status       (rsp.status),
		.rsp_popped_value (rsp.popped_value)
	);

endmodule
